// ----- rtl/sidec_pkg.sv -----
// Shared types, constants and helpers for the signed decimal text converter.
`timescale 1ns / 1ps
package sidec_pkg;

  // Default number of decimal digit positions
  localparam int DIGIT_COUNT_DEF = 10;

  localparam int VALUE_W = 32;
  localparam int MAG_W   = 32;
  localparam int CHAR_W  = 6;
  localparam int DIGIT_W = 4;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

  // Data handed from one digit cell to the next
  typedef struct packed {
    logic             valid;
    logic             neg;
    logic             started;
    logic [MAG_W-1:0] rem;
  } chain_t;

  // 10 to the power k, evaluated at elaboration
  function automatic logic [63:0] pow10(input int unsigned k);
    logic [63:0] acc;
    acc = 64'd1;
    for (int unsigned i = 0; i < k; i++) begin
      acc = acc * 64'd10;
    end
    return acc;
  endfunction

endpackage

// ----- rtl/sidec_cell.sv -----
// One digit cell: picks its decimal digit and passes the remainder down the chain.
`timescale 1ns / 1ps
module sidec_cell #(
  parameter int DIGIT_COUNT = sidec_pkg::DIGIT_COUNT_DEF,
  parameter int POS = 0,
  localparam int IdxW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  sidec_pkg::chain_t                             prev,
  input  logic [IdxW-1:0]                               prev_lead,
  input  logic [DIGIT_COUNT*sidec_pkg::DIGIT_W-1:0]     prev_digits,
  output sidec_pkg::chain_t                             nxt,
  output logic [IdxW-1:0]                               nxt_lead,
  output logic [DIGIT_COUNT*sidec_pkg::DIGIT_W-1:0]     nxt_digits
);
  import sidec_pkg::*;

  // Weight of this digit position
  localparam logic [63:0] POWER = pow10(DIGIT_COUNT - 1 - POS);

  logic                           valid;
  logic                           neg;
  logic                           started;
  logic [MAG_W-1:0]               rem;
  logic [IdxW-1:0]                lead;
  logic [DIGIT_COUNT*DIGIT_W-1:0] digits;

  logic [DIGIT_W-1:0]             digit;
  logic [MAG_W-1:0]               sub;
  logic [MAG_W-1:0]               rem_next;
  logic [DIGIT_COUNT*DIGIT_W-1:0] digits_next;

  // Largest multiple of the weight that fits, at most 9 times; a remainder at or above 10x weight is capped at 9
  always_comb begin
    logic [63:0] prod;
    digit = '0;
    sub   = '0;
    for (int c = 1; c <= 9; c++) begin
      prod = POWER * 64'(c);
      if ({32'd0, prev.rem} >= prod) begin
        digit = DIGIT_W'(c);
        sub   = prod[MAG_W-1:0];
      end
    end
    rem_next    = prev.rem - sub;
    digits_next = prev_digits;
    digits_next[POS*DIGIT_W +: DIGIT_W] = digit;
  end

  // Control: valid travels with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= prev.valid;
    end
  end

  // Payload moves every cycle
  always_ff @(posedge clk) begin
    neg     <= prev.neg;
    started <= prev.started | (digit != '0);
    rem     <= rem_next;
    digits  <= digits_next;
    if (!prev.started && digit != '0) begin
      lead <= IdxW'(POS);
    end else begin
      lead <= prev_lead;
    end
  end

  assign nxt.valid   = valid;
  assign nxt.neg     = neg;
  assign nxt.started = started;
  assign nxt.rem     = rem;
  assign nxt_lead    = lead;
  assign nxt_digits  = digits;

endmodule

// ----- rtl/sidec_emit.sv -----
// Character emitter: turns the finished digit set into a run of ASCII characters.
`timescale 1ns / 1ps
module sidec_emit #(
  parameter int DIGIT_COUNT = sidec_pkg::DIGIT_COUNT_DEF,
  localparam int IdxW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  sidec_pkg::chain_t                         tail,
  input  logic [IdxW-1:0]                           tail_lead,
  input  logic [DIGIT_COUNT*sidec_pkg::DIGIT_W-1:0] tail_digits,
  input  logic                                      out_stall,
  output logic                                      out_valid,
  output logic [sidec_pkg::CHAR_W-1:0]              char_code,
  output logic                                      last
);
  import sidec_pkg::*;

  localparam logic [IdxW-1:0] LAST_IDX = IdxW'(DIGIT_COUNT - 1);

  logic                           active;
  logic                           neg_pend;
  logic [IdxW-1:0]                idx;
  logic [DIGIT_COUNT*DIGIT_W-1:0] digits;
  logic                           slot_free;
  logic [DIGIT_W-1:0]             cur_digit;

  assign slot_free = !out_valid || !out_stall;
  assign cur_digit = digits[idx*DIGIT_W +: DIGIT_W];

  // Sign first, then digits from the first significant one down to the units
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (slot_free) begin
        out_valid <= active;
      end
      if (tail.valid) begin
        active   <= 1'b1;
        neg_pend <= tail.neg;
        idx      <= tail_lead;
        digits   <= tail_digits;
      end else if (active && slot_free) begin
        if (neg_pend) begin
          char_code <= CHAR_MINUS;
          last      <= 1'b0;
          neg_pend  <= 1'b0;
        end else begin
          char_code <= CHAR_ZERO + {2'b00, cur_digit};
          last      <= (idx == LAST_IDX);
          if (idx == LAST_IDX) begin
            active <= 1'b0;
          end else begin
            idx <= idx + IdxW'(1);
          end
        end
      end
    end
  end

endmodule

// ----- rtl/signed_int_to_decimal_ascii_core.sv -----
// Top level: signed 32-bit integer to decimal ASCII text, most significant first.
// Each number gives up to 11 characters; the digit cell chain resolves one position per cycle,
// and one character leaves per output transfer.
// One number is in flight at a time; in_stall stays high until its last character transfers.
// Reset (rst, synchronous) clears all valid flags; no clearing pass is needed.
`timescale 1ns / 1ps
module signed_int_to_decimal_ascii_core #(
  parameter int DIGIT_COUNT = sidec_pkg::DIGIT_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [sidec_pkg::VALUE_W-1:0] value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sidec_pkg::CHAR_W-1:0]        char_code,
  output logic                                last
);
  import sidec_pkg::*;

  localparam int IdxW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [63:0] LIMIT = pow10(DIGIT_COUNT) - 64'd1;

  chain_t                         chain  [DIGIT_COUNT+1];
  logic [IdxW-1:0]                lead   [DIGIT_COUNT+1];
  logic [DIGIT_COUNT*DIGIT_W-1:0] digits [DIGIT_COUNT+1];

  logic             busy;
  logic             in_xfer;
  logic             out_xfer;
  logic             head_valid;
  logic             head_neg;
  logic [MAG_W-1:0] head_mag;
  logic [MAG_W-1:0] mag;
  logic [MAG_W-1:0] mag_sat;

  assign in_stall = busy;
  assign in_xfer  = in_valid && !busy;
  assign out_xfer = out_valid && !out_stall && last;

  // Magnitude without overflow, saturated to the digit positions available
  always_comb begin
    mag     = value[VALUE_W-1] ? (MAG_W'(0) - MAG_W'(value)) : MAG_W'(value);
    mag_sat = ({32'd0, mag} > LIMIT) ? LIMIT[MAG_W-1:0] : mag;
  end

  // Busy from input transfer until the final character transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      head_valid <= 1'b0;
    end else begin
      head_valid <= in_xfer;
      if (in_xfer) begin
        busy <= 1'b1;
      end else if (out_xfer) begin
        busy <= 1'b0;
      end
    end
  end

  // Head register feeding the first cell
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      head_neg <= value[VALUE_W-1];
      head_mag <= mag_sat;
    end
  end

  assign chain[0].valid   = head_valid;
  assign chain[0].neg     = head_neg;
  assign chain[0].started = 1'b0;
  assign chain[0].rem     = head_mag;
  assign lead[0]          = IdxW'(DIGIT_COUNT - 1);
  assign digits[0]        = '0;

  // Row of digit cells, most significant position first
  for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_cell
    sidec_cell #(
      .DIGIT_COUNT (DIGIT_COUNT),
      .POS         (g)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .prev        (chain[g]),
      .prev_lead   (lead[g]),
      .prev_digits (digits[g]),
      .nxt         (chain[g+1]),
      .nxt_lead    (lead[g+1]),
      .nxt_digits  (digits[g+1])
    );
  end

  sidec_emit #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_emit (
    .clk         (clk),
    .rst         (rst),
    .tail        (chain[DIGIT_COUNT]),
    .tail_lead   (lead[DIGIT_COUNT]),
    .tail_digits (digits[DIGIT_COUNT]),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .char_code   (char_code),
    .last        (last)
  );

  // A character is only offered while a number is in flight
  a_out_needs_busy : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> busy)
    else $error("character offered with no number in flight");

  // Input transfer locks the input side
  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> busy)
    else $error("busy not set after input transfer");

  // Nothing follows the final character of a run
  a_last_ends : assert property (@(posedge clk) disable iff (rst)
    out_xfer |=> !out_valid)
    else $error("character offered after the last one");

  // Only minus sign or decimal digits leave the block
  a_char_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_code == CHAR_MINUS ||
                   (char_code >= CHAR_ZERO && char_code <= CHAR_NINE)))
    else $error("character code out of range");

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the signed integer to decimal ASCII text converter.
`timescale 1ns / 1ps
module tb_top;
  import sidec_pkg::*;

  localparam int DIGITS         = DIGIT_COUNT_DEF;
  localparam int ITEMS_PER_MODE = 112;
  localparam int WATCHDOG_LIMIT = 2000;

  // One expected character of a number's text
  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [CHAR_W-1:0]         char_code;
  logic                      last;

  logic [VALUE_W-1:0] number_q[$];
  text_char_t         text_q[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int chars_checked  = 0;
  int numbers_done   = 0;
  int negatives_sent = 0;
  int idle_cycles    = 0;

  signed_int_to_decimal_ascii_core #(
    .DIGIT_COUNT(DIGITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .char_code(char_code),
    .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Decimal text of one number, appended to the expected character store
  function automatic void predict_text(input logic [VALUE_W-1:0] num);
    logic        neg;
    logic        started;
    logic [63:0] mag;
    logic [63:0] place;
    logic [63:0] limit;
    int          count;
    neg = num[VALUE_W-1];
    mag = neg ? (64'h1_0000_0000 - {32'd0, num}) : {32'd0, num};
    place = 64'd1;
    for (int k = 1; k < DIGITS; k++) begin
      place = place * 64'd10;
    end
    limit = place * 64'd10 - 64'd1;
    if (mag > limit) begin
      mag = limit;  // too few digit positions: all nines
    end
    started = 1'b0;
    if (neg) begin
      text_q.push_back('{code: CHAR_MINUS, last: 1'b0});
      negatives_sent++;
    end
    for (int k = 0; k < DIGITS; k++) begin
      count = 0;
      while (mag >= place && count < 9) begin
        mag = mag - place;
        count++;
      end
      if (count != 0) begin
        started = 1'b1;
      end
      // leading zeros dropped, units digit always written
      if (started || place == 64'd1) begin
        text_q.push_back('{code: CHAR_ZERO + CHAR_W'(count), last: 1'b0});
      end
      place = place / 64'd10;
    end
    text_q[text_q.size() - 1].last = 1'b1;
  endfunction

  // Random value with a random digit count, sometimes fully random bits
  function automatic logic [VALUE_W-1:0] random_number();
    int unsigned n_dig;
    int unsigned lo;
    int unsigned hi;
    int unsigned mag;
    if ($urandom_range(9) == 0) begin
      return $urandom();
    end
    n_dig = $urandom_range(10, 1);
    lo = 1;
    for (int i = 1; i < n_dig; i++) begin
      lo = lo * 10;
    end
    hi = (n_dig == 10) ? 32'h7FFF_FFFF : lo * 10 - 1;
    if (n_dig == 1) begin
      lo = 0;
    end
    mag = $urandom_range(hi, lo);
    return ($urandom_range(1) == 1) ? -mag : mag;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatches++;
  endtask

  // Driver: feeds queued numbers, predicts each one on its transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_text(value);
      end
      if (!in_valid || !in_stall) begin
        if (number_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          value    <= number_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every character transfer against the oldest expectation
  always @(posedge clk) begin
    text_char_t exp_char;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (text_q.size() == 0) begin
          report_mismatch($sformatf("unexpected character %0d", char_code));
        end else begin
          exp_char = text_q.pop_front();
          chars_checked++;
          if (char_code !== exp_char.code) begin
            report_mismatch($sformatf("char_code %0d, expected %0d",
                                      char_code, exp_char.code));
          end
          if (last !== exp_char.last) begin
            report_mismatch($sformatf("last %0b, expected %0b", last, exp_char.last));
          end
          if (exp_char.last) begin
            numbers_done++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus: directed values, then random values under each idling mode
  initial begin
    int send_pct[4];
    int recv_pct[4];
    send_pct = '{0, 61, 0, 21};
    recv_pct = '{0, 0, 61, 21};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // extremes, zero, digit-count boundaries
    number_q.push_back(32'd0);
    number_q.push_back(32'd1);
    number_q.push_back(-32'sd1);
    number_q.push_back(32'd9);
    number_q.push_back(32'd10);
    number_q.push_back(-32'sd10);
    number_q.push_back(32'd99);
    number_q.push_back(32'd100);
    number_q.push_back(32'd999999999);
    number_q.push_back(32'd1000000000);
    number_q.push_back(-32'sd999999999);
    number_q.push_back(-32'sd1000000000);
    number_q.push_back(32'd1000000001);
    number_q.push_back(32'd1234567890);
    number_q.push_back(-32'sd1234567890);
    number_q.push_back(32'h7FFF_FFFF);
    number_q.push_back(32'h8000_0000);
    number_q.push_back(32'h8000_0001);
    number_q.push_back(32'd1000000);
    number_q.push_back(32'hAAAA_AAAA);
    number_q.push_back(32'h5555_5555);

    for (int m = 0; m < 4; m++) begin
      // sender holds off until every pending character has come out
      while (number_q.size() != 0 || in_valid || text_q.size() != 0) begin
        @(posedge clk);
      end
      send_idle_pct  = send_pct[m];
      recv_stall_pct = recv_pct[m];
      for (int i = 0; i < ITEMS_PER_MODE; i++) begin
        number_q.push_back(random_number());
      end
    end

    while (number_q.size() != 0 || in_valid || text_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DIGITS + 4) @(posedge clk);
    if (text_q.size() != 0) begin
      report_mismatch($sformatf("%0d characters never arrived", text_q.size()));
    end

    $display("Converted %0d numbers (%0d negative) into %0d checked characters,",
             numbers_done, negatives_sent, chars_checked);
    $display("under no idling, sender gaps, receiver stalls and both; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
